// ----- hdl/textured_fragment_blend_macros.svh -----
// Assertion helpers shared by the blend pipeline modules.
`ifndef TEXTURED_FRAGMENT_BLEND_MACROS_SVH
`define TEXTURED_FRAGMENT_BLEND_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define TFB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that must also hold during reset.
`define TFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/tfb_pkg.sv -----
package tfb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 4;
  localparam int unsigned PixW    = ChanW * NumChan;
  localparam int unsigned FracW   = 8;
  localparam int unsigned WeightW = FracW + 1;
  localparam int unsigned HorzW   = 16;
  localparam int unsigned AccW    = 25;
  localparam int unsigned SumW    = 16;

  localparam logic [PixW-1:0]    AlphaOpaque = 32'hFF00_0000;
  localparam logic [ChanW-1:0]   ChanMax     = 8'hFF;
  localparam logic [ChanW-1:0]   ChanZero    = 8'h00;
  localparam logic [WeightW-1:0] WeightOne   = 9'd256;
  localparam logic [AccW-1:0]    RoundHalf   = 25'd32768;
  localparam logic [SumW:0]      BlendRound  = 17'd127;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [PixW-1:0]  pixel_t;

  // Fragment data that rides alongside the filter pipeline
  typedef struct packed {
    pixel_t dest;
    pixel_t shade;
    logic   use_texture;
  } frag_t;

  typedef enum logic [1:0] {
    BlendKeep,
    BlendOpaque,
    BlendMix
  } blend_mode_e;

  // floor(x / 255) by reciprocal approximation, exact for x below 65280,
  // which covers every product and blend sum fed to it
  function automatic chan_t div255(input logic [SumW-1:0] x);
    logic [SumW:0] t;
    t = {1'b0, x} + {9'b0, x[SumW-1:ChanW]} + 17'd1;
    return t[SumW-1:ChanW];
  endfunction

  function automatic chan_t get_chan(input pixel_t p, input int unsigned idx);
    return p[idx*ChanW +: ChanW];
  endfunction

endpackage

// ----- hdl/tfb_bilerp.sv -----
// Two-stage bilinear filter: horizontal lerp, then vertical lerp with rounding
module tfb_bilerp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  tfb_pkg::frag_t             frag_i,
  input  tfb_pkg::pixel_t            texel_tl_i,
  input  tfb_pkg::pixel_t            texel_tr_i,
  input  tfb_pkg::pixel_t            texel_bl_i,
  input  tfb_pkg::pixel_t            texel_br_i,
  input  logic [tfb_pkg::FracW-1:0]  frac_h_i,
  input  logic [tfb_pkg::FracW-1:0]  frac_v_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output tfb_pkg::frag_t             frag_o,
  output tfb_pkg::pixel_t            filt_o
);

  // Stage A registers
  logic                              va_q;
  tfb_pkg::frag_t                    frag_a_q;
  logic [tfb_pkg::HorzW-1:0]         top_a_q [tfb_pkg::NumChan];
  logic [tfb_pkg::HorzW-1:0]         bot_a_q [tfb_pkg::NumChan];
  logic [tfb_pkg::HorzW-1:0]         top_a_d [tfb_pkg::NumChan];
  logic [tfb_pkg::HorzW-1:0]         bot_a_d [tfb_pkg::NumChan];
  logic [tfb_pkg::WeightW-1:0]       wy0_a_q, wy1_a_q;

  // Stage B registers
  logic                              vb_q;
  tfb_pkg::frag_t                    frag_b_q;
  tfb_pkg::pixel_t                   filt_b_q, filt_b_d;

  logic                              en_a, en_b;
  logic [tfb_pkg::WeightW-1:0]       wx0, wx1;

  // Stall chain: a stage moves when empty or when the next one moves
  assign en_b    = !vb_q || !stall_i;
  assign en_a    = !va_q || en_b;
  assign stall_o = !en_a;

  assign wx1 = {1'b0, frac_h_i};
  assign wx0 = tfb_pkg::WeightOne - wx1;

  // Horizontal lerp of both rows, per channel
  always_comb begin
    logic [tfb_pkg::HorzW:0] pt, pb;
    for (int unsigned c = 0; c < tfb_pkg::NumChan; c++) begin
      pt = {9'b0, tfb_pkg::get_chan(texel_tl_i, c)} * {8'b0, wx0}
         + {9'b0, tfb_pkg::get_chan(texel_tr_i, c)} * {8'b0, wx1};
      pb = {9'b0, tfb_pkg::get_chan(texel_bl_i, c)} * {8'b0, wx0}
         + {9'b0, tfb_pkg::get_chan(texel_br_i, c)} * {8'b0, wx1};
      top_a_d[c] = pt[tfb_pkg::HorzW-1:0];
      bot_a_d[c] = pb[tfb_pkg::HorzW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      frag_a_q <= frag_i;
      top_a_q  <= top_a_d;
      bot_a_q  <= bot_a_d;
      wy1_a_q  <= {1'b0, frac_v_i};
      wy0_a_q  <= tfb_pkg::WeightOne - {1'b0, frac_v_i};
    end
  end

  // Vertical lerp and rounding to 8 bits
  always_comb begin
    logic [tfb_pkg::AccW-1:0] acc;
    for (int unsigned c = 0; c < tfb_pkg::NumChan; c++) begin
      acc = {9'b0, top_a_q[c]} * {16'b0, wy0_a_q}
          + {9'b0, bot_a_q[c]} * {16'b0, wy1_a_q}
          + tfb_pkg::RoundHalf;
      filt_b_d[c*tfb_pkg::ChanW +: tfb_pkg::ChanW] = acc[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      frag_b_q <= frag_a_q;
      filt_b_q <= filt_b_d;
    end
  end

  assign valid_o = vb_q;
  assign frag_o  = frag_b_q;
  assign filt_o  = filt_b_q;

endmodule

// ----- hdl/tfb_modulate.sv -----
`include "textured_fragment_blend_macros.svh"

// One stage: textured items take shade * texel / 255, flat items take the shade
module tfb_modulate (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  tfb_pkg::frag_t  frag_i,
  input  tfb_pkg::pixel_t filt_i,
  output logic            valid_o,
  input  logic            stall_i,
  output tfb_pkg::frag_t  frag_o,
  output tfb_pkg::pixel_t src_o
);

  logic            v_q;
  logic            en;
  tfb_pkg::frag_t  frag_q;
  tfb_pkg::pixel_t src_q, src_d;

  assign en      = !v_q || !stall_i;
  assign stall_o = !en;

  // Per-channel modulate
  always_comb begin
    logic [tfb_pkg::SumW-1:0] prod;
    for (int unsigned c = 0; c < tfb_pkg::NumChan; c++) begin
      prod = {8'b0, tfb_pkg::get_chan(frag_i.shade, c)}
           * {8'b0, tfb_pkg::get_chan(filt_i, c)};
      src_d[c*tfb_pkg::ChanW +: tfb_pkg::ChanW] =
        frag_i.use_texture ? tfb_pkg::div255(prod) : tfb_pkg::get_chan(frag_i.shade, c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      frag_q <= frag_i;
      src_q  <= src_d;
    end
  end

  assign valid_o = v_q;
  assign frag_o  = frag_q;
  assign src_o   = src_q;

  // Modulation never brightens: each channel stays at or below the shade channel
  `TFB_ASSERT_RST(a_mod_not_above_shade, clk_i, rst_ni, v_q |-> (src_q[7:0] <= frag_q.shade[7:0] && src_q[15:8] <= frag_q.shade[15:8] && src_q[23:16] <= frag_q.shade[23:16] && src_q[31:24] <= frag_q.shade[31:24]), "modulated channel exceeds shade channel")

endmodule

// ----- hdl/tfb_blend.sv -----
`include "textured_fragment_blend_macros.svh"

// Two stages: weighted sums per channel, then divide by 255 and pick the rule
module tfb_blend (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  tfb_pkg::frag_t  frag_i,
  input  tfb_pkg::pixel_t src_i,
  output logic            valid_o,
  input  logic            stall_i,
  output tfb_pkg::pixel_t pixel_o
);

  localparam int unsigned NumColour = tfb_pkg::NumChan - 1;

  // Stage C registers
  logic                      vc_q;
  tfb_pkg::blend_mode_e      mode_c_q, mode_c_d;
  tfb_pkg::pixel_t           src_c_q, dest_c_q;
  logic [tfb_pkg::SumW-1:0]  sum_c_q [NumColour];
  logic [tfb_pkg::SumW-1:0]  sum_c_d [NumColour];

  // Stage D registers
  logic                      vd_q;
  tfb_pkg::pixel_t           pix_d_q, pix_d_d;

  logic                      en_c, en_d;
  tfb_pkg::chan_t            alpha, inv_alpha;

  assign en_d    = !vd_q || !stall_i;
  assign en_c    = !vc_q || en_d;
  assign stall_o = !en_c;

  assign alpha     = src_i[31:24];
  assign inv_alpha = tfb_pkg::ChanMax - alpha;

  // Blend rule from source alpha
  always_comb begin
    if (alpha == tfb_pkg::ChanZero) begin
      mode_c_d = tfb_pkg::BlendKeep;
    end else if (alpha == tfb_pkg::ChanMax) begin
      mode_c_d = tfb_pkg::BlendOpaque;
    end else begin
      mode_c_d = tfb_pkg::BlendMix;
    end
  end

  // s*a + d*(255-a) + 127 per colour channel
  always_comb begin
    logic [tfb_pkg::SumW:0] s;
    for (int unsigned c = 0; c < NumColour; c++) begin
      s = {9'b0, tfb_pkg::get_chan(src_i, c)} * {9'b0, alpha}
        + {9'b0, tfb_pkg::get_chan(frag_i.dest, c)} * {9'b0, inv_alpha}
        + tfb_pkg::BlendRound;
      sum_c_d[c] = s[tfb_pkg::SumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_c) begin
      vc_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      mode_c_q <= mode_c_d;
      src_c_q  <= src_i;
      dest_c_q <= frag_i.dest;
      sum_c_q  <= sum_c_d;
    end
  end

  // Final pixel
  always_comb begin
    pix_d_d = tfb_pkg::AlphaOpaque;
    unique case (mode_c_q)
      tfb_pkg::BlendKeep:   pix_d_d = dest_c_q;
      tfb_pkg::BlendOpaque: pix_d_d = src_c_q | tfb_pkg::AlphaOpaque;
      tfb_pkg::BlendMix: begin
        for (int unsigned c = 0; c < NumColour; c++) begin
          pix_d_d[c*tfb_pkg::ChanW +: tfb_pkg::ChanW] = tfb_pkg::div255(sum_c_q[c]);
        end
      end
      default:              pix_d_d = dest_c_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_d) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      pix_d_q <= pix_d_d;
    end
  end

  assign valid_o = vd_q;
  assign pixel_o = pix_d_q;

  // Every rule but keep writes an opaque pixel
  `TFB_ASSERT_RST(a_written_opaque, clk_i, rst_ni, $past(en_d && vc_q && mode_c_q != tfb_pkg::BlendKeep) |-> pix_d_q[31:24] == tfb_pkg::ChanMax, "blended pixel not opaque")

endmodule

// ----- hdl/textured_fragment_blend.sv -----
// Per-fragment texture filter, modulate and blend. Each accepted item passes the
// bilinear filter (two stages), modulate (one) and blend (two) to give one blended
// pixel; a new item can be taken every cycle unless stalled; stall on the output
// backs up through the stages, and empty stages are filled while the output
// waits, so a new item enters whenever any stage ahead of it is free. Pixels are
// packed R in bits 7:0 up to A in bits 31:24. Flat items blend the shade colour
// over the destination with the shade alpha; textured items filter the four
// texels with 8-bit fractions, scale by the shade colour and blend with the
// resulting alpha. Alpha 0 keeps the destination, alpha 255 writes the source
// opaque, anything else mixes R, G, B and writes alpha 255.
`include "textured_fragment_blend_macros.svh"

module textured_fragment_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [tfb_pkg::PixW-1:0]  dest_pixel_i,
  input  logic [tfb_pkg::PixW-1:0]  shade_colour_i,
  input  logic                      use_texture_i,
  input  logic [tfb_pkg::PixW-1:0]  texel_top_left_i,
  input  logic [tfb_pkg::PixW-1:0]  texel_top_right_i,
  input  logic [tfb_pkg::PixW-1:0]  texel_bottom_left_i,
  input  logic [tfb_pkg::PixW-1:0]  texel_bottom_right_i,
  input  logic [tfb_pkg::FracW-1:0] frac_horizontal_i,
  input  logic [tfb_pkg::FracW-1:0] frac_vertical_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [tfb_pkg::PixW-1:0]  blended_pixel_o
);

  tfb_pkg::frag_t  frag_in;
  tfb_pkg::frag_t  frag_filt, frag_mod;
  tfb_pkg::pixel_t filt, src;
  logic            filt_valid, filt_stall;
  logic            mod_valid, mod_stall;

  assign frag_in = '{dest: dest_pixel_i, shade: shade_colour_i, use_texture: use_texture_i};

  // Bilinear filter
  tfb_bilerp u_bilerp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .stall_o    (in_stall_o),
    .frag_i     (frag_in),
    .texel_tl_i (texel_top_left_i),
    .texel_tr_i (texel_top_right_i),
    .texel_bl_i (texel_bottom_left_i),
    .texel_br_i (texel_bottom_right_i),
    .frac_h_i   (frac_horizontal_i),
    .frac_v_i   (frac_vertical_i),
    .valid_o    (filt_valid),
    .stall_i    (filt_stall),
    .frag_o     (frag_filt),
    .filt_o     (filt)
  );

  // Modulate by shade colour
  tfb_modulate u_modulate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (filt_valid),
    .stall_o (filt_stall),
    .frag_i  (frag_filt),
    .filt_i  (filt),
    .valid_o (mod_valid),
    .stall_i (mod_stall),
    .frag_o  (frag_mod),
    .src_o   (src)
  );

  // Blend over destination
  tfb_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mod_valid),
    .stall_o (mod_stall),
    .frag_i  (frag_mod),
    .src_i   (src),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .pixel_o (blended_pixel_o)
  );

  // An empty output register lets the whole pipeline advance
  `TFB_ASSERT_RST(a_empty_out_no_stall, clk_i, rst_ni, !out_valid_o |-> !in_stall_o, "input stalled with empty output")
  // No downstream stall means no upstream stall
  `TFB_ASSERT_ALWAYS(a_free_out_no_stall, clk_i, !out_stall_i |-> !in_stall_o, "input stalled while output free")

endmodule
